### hdl/ckpd_pkg.sv
// Package: packet geometry constants and the byte-wide CRC-16/MODBUS update.
`timescale 1ns / 1ps
`default_nettype none
package ckpd_pkg;

    localparam int PACKET_BYTES  = 128;
    localparam int HEADER_BYTES  = 3;
    localparam int PAYLOAD_BYTES = PACKET_BYTES - HEADER_BYTES;
    localparam int POS_W         = $clog2(PACKET_BYTES);
    localparam int BYTE_W        = 8;
    localparam int CRC_W         = 16;
    localparam int PLEN_W        = 7;

    localparam logic [POS_W-1:0]  POS_LENGTH = POS_W'(0);
    localparam logic [POS_W-1:0]  POS_CRC_HI = POS_W'(1);
    localparam logic [POS_W-1:0]  POS_CRC_LO = POS_W'(2);
    localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(PACKET_BYTES - 1);

    localparam logic [BYTE_W-1:0] PAYLOAD_MAX = BYTE_W'(PAYLOAD_BYTES);
    localparam logic [BYTE_W-1:0] HEADER_LEN  = BYTE_W'(HEADER_BYTES);

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [POS_W-1:0]  pos_t;

    function automatic crc_t crc_byte_update(input crc_t crc_in, input byte_t data);
        crc_t crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

### hdl/crc16_checked_packet_deframer.sv
// Top level: fixed-size packet deframer with length keep flags and CRC-16/MODBUS check.
// An accepted payload byte's result is registered on the output register in the next cycle.
// Throughput: one byte per cycle unless a full output register is held by res_ready low;
// the byte-wide CRC update and the header decode sit between the state and output registers.
// Header bytes (positions 0 to 2) produce no result.
// Reset: asynchronous, active low; position, length and received CRC clear to zero,
// running CRC to 0xFFFF, output register empty.
`timescale 1ns / 1ps
`default_nettype none
module crc16_checked_packet_deframer
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pkt_valid,
    output      logic                   pkt_ready,
    input  wire ckpd_pkg::byte_t        pkt_byte,
    output      logic                   res_valid,
    input  wire logic                   res_ready,
    output      ckpd_pkg::byte_t        data_byte,
    output      logic                   keep,
    output      logic                   last_of_packet,
    output      logic                   crc_ok,
    output      logic [6:0]             payload_length
);
    import ckpd_pkg::*;

    pos_t   byte_position_reg, byte_position_next;
    byte_t  declared_length_reg, declared_length_next;
    crc_t   received_crc_reg, received_crc_next;
    crc_t   running_crc_reg, running_crc_next;

    logic   res_valid_reg, res_valid_next;
    byte_t  data_byte_reg, data_byte_next;
    logic   keep_reg, keep_next;
    logic   last_reg, last_next;
    logic   crc_ok_reg, crc_ok_next;
    logic [PLEN_W-1:0] payload_length_reg, payload_length_next;

    logic   accept;
    logic   is_last;
    byte_t  payload_idx;
    crc_t   crc_updated;

    assign pkt_ready      = !res_valid_reg || res_ready;
    assign accept         = pkt_valid && pkt_ready;
    assign is_last        = (byte_position_reg == POS_LAST);
    assign payload_idx    = BYTE_W'(byte_position_reg) - HEADER_LEN;
    assign crc_updated    = crc_byte_update(running_crc_reg, pkt_byte);

    assign res_valid      = res_valid_reg;
    assign data_byte      = data_byte_reg;
    assign keep           = keep_reg;
    assign last_of_packet = last_reg;
    assign crc_ok         = crc_ok_reg;
    assign payload_length = payload_length_reg;

    always_comb
    begin
        byte_position_next   = byte_position_reg;
        declared_length_next = declared_length_reg;
        received_crc_next    = received_crc_reg;
        running_crc_next     = running_crc_reg;
        res_valid_next       = res_valid_reg && !res_ready;
        data_byte_next       = data_byte_reg;
        keep_next            = keep_reg;
        last_next            = last_reg;
        crc_ok_next          = crc_ok_reg;
        payload_length_next  = payload_length_reg;

        if (accept)
        begin
            byte_position_next = is_last ? POS_LENGTH : byte_position_reg + POS_W'(1);
            case (byte_position_reg)
                POS_LENGTH:
                begin
                    declared_length_next = (pkt_byte > PAYLOAD_MAX) ? PAYLOAD_MAX : pkt_byte;
                    running_crc_next     = CRC_INIT;
                end
                POS_CRC_HI:
                begin
                    received_crc_next = {pkt_byte, received_crc_reg[7:0]};
                end
                POS_CRC_LO:
                begin
                    received_crc_next = {received_crc_reg[15:8], pkt_byte};
                end
                default:
                begin
                    running_crc_next    = crc_updated;
                    res_valid_next      = 1'b1;
                    data_byte_next      = pkt_byte;
                    keep_next           = (payload_idx < declared_length_reg);
                    last_next           = is_last;
                    crc_ok_next         = is_last && (crc_updated == received_crc_reg);
                    payload_length_next = declared_length_reg[PLEN_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            declared_length_reg <= '0;
            received_crc_reg    <= '0;
            running_crc_reg     <= CRC_INIT;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            byte_position_reg   <= byte_position_next;
            declared_length_reg <= declared_length_next;
            received_crc_reg    <= received_crc_next;
            running_crc_reg     <= running_crc_next;
            res_valid_reg       <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_byte_reg      <= data_byte_next;
        keep_reg           <= keep_next;
        last_reg           <= last_next;
        crc_ok_reg         <= crc_ok_next;
        payload_length_reg <= payload_length_next;
    end

endmodule
`default_nettype wire
